// ----- hdl/bbcm_pkg.sv -----
// bbcm_pkg: request, response, entry and update types of the block buffer cache manager
// no dependencies; used by bbcm_cell and block_buffer_cache_manager_core
package bbcm_pkg;

  // request kinds
  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_POLL    = 2'd1;
  localparam logic [1:0] REQ_FILLED  = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // response status codes
  localparam logic [2:0] ST_READY    = 3'd0;
  localparam logic [2:0] ST_FILL     = 3'd1;
  localparam logic [2:0] ST_PENDING  = 3'd2;
  localparam logic [2:0] ST_IOERR    = 3'd3;
  localparam logic [2:0] ST_NOBUF    = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;

  localparam logic [15:0] REF_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
    logic        read_error;
  } bbcm_req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic [2:0] status;
  } bbcm_resp_t;

  // per-buffer tag and state
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [15:0] refs;
    logic        in_cache;
    logic        busy;
    logic        err;
  } bbcm_entry_t;

  // update commands broadcast to every cell
  typedef struct packed {
    logic tgt_we;   // target cell loads the new entry and list positions
    logic e_pop;    // empty fifo head removed: shift positions down
    logic r_dec;    // recency entry removed: positions above it shift down
    logic r_inc;    // recency head insert: positions shift up
  } bbcm_bcast_t;

endpackage

// ----- hdl/bbcm_cell.sv -----
// bbcm_cell: one buffer entry of the rotating chain, with its list positions
// depends on bbcm_pkg
module bbcm_cell import bbcm_pkg::*; #(
  parameter int IW = 5,
  parameter int K  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  bbcm_entry_t       nbr_ent_i,
  input  logic              nbr_em_i,
  input  logic [IW-1:0]     nbr_epos_i,
  input  logic              nbr_rm_i,
  input  logic [IW-1:0]     nbr_rpos_i,
  input  bbcm_bcast_t       bcast_i,
  input  logic [IW-1:0]     tgt_id_i,
  input  bbcm_entry_t       tgt_ent_i,
  input  logic              tgt_em_i,
  input  logic [IW-1:0]     tgt_epos_i,
  input  logic              tgt_rm_i,
  input  logic [IW-1:0]     tgt_rpos_i,
  input  logic [IW-1:0]     rdec_pos_i,
  output bbcm_entry_t       ent_o,
  output logic              em_o,
  output logic [IW-1:0]     epos_o,
  output logic              rm_o,
  output logic [IW-1:0]     rpos_o
);

  bbcm_entry_t   ent_q, ent_d;
  logic          em_q, em_d, rm_q, rm_d;
  logic [IW-1:0] epos_q, epos_d, rpos_q, rpos_d;

  always_comb begin
    ent_d  = ent_q;
    em_d   = em_q;
    epos_d = epos_q;
    rm_d   = rm_q;
    rpos_d = rpos_q;
    if (shift_i) begin
      ent_d  = nbr_ent_i;
      em_d   = nbr_em_i;
      epos_d = nbr_epos_i;
      rm_d   = nbr_rm_i;
      rpos_d = nbr_rpos_i;
    end else if (bcast_i.tgt_we && tgt_id_i == IW'(K)) begin
      ent_d  = tgt_ent_i;
      em_d   = tgt_em_i;
      epos_d = tgt_epos_i;
      rm_d   = tgt_rm_i;
      rpos_d = tgt_rpos_i;
    end else begin
      if (bcast_i.e_pop && em_q) epos_d = epos_q - IW'(1);
      if (rm_q && bcast_i.r_dec && rpos_q > rdec_pos_i) rpos_d = rpos_q - IW'(1);
      if (rm_q && bcast_i.r_inc) rpos_d = rpos_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q  <= '0;
      em_q   <= 1'b1;
      epos_q <= IW'(K);
      rm_q   <= 1'b0;
      rpos_q <= '0;
    end else begin
      ent_q  <= ent_d;
      em_q   <= em_d;
      epos_q <= epos_d;
      rm_q   <= rm_d;
      rpos_q <= rpos_d;
    end
  end

  assign ent_o  = ent_q;
  assign em_o   = em_q;
  assign epos_o = epos_q;
  assign rm_o   = rm_q;
  assign rpos_o = rpos_q;

endmodule

// ----- hdl/block_buffer_cache_manager_core.sv -----
// block_buffer_cache_manager_core: top level of the block buffer cache manager
// depends on bbcm_pkg and bbcm_cell
//
// A pool of NUM_BUFS block buffers sits in a ring of cells, one buffer per cell,
// each cell holding the tag, reference count, busy and error marks and its place
// in the empty fifo and in the recency list. One request is handled at a time.
// An acquire first rotates the ring once so that every tag passes the compare stage
// at cell 0, then the update is applied to the chosen cell and to the list positions
// of all cells. Poll, fill complete and release skip the rotation and go straight to
// the update. A finished response waits in an output register, and the next request
// is taken while it waits; a stalled output holds the update cycle of the following
// request.
module block_buffer_cache_manager_core import bbcm_pkg::*; #(
  parameter int NUM_BUFS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bbcm_req_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bbcm_resp_t out_resp_o
);

  localparam int IW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int CW = IW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0]    state_q, state_d;
  bbcm_req_t     req_q;
  logic [IW-1:0] cnt_q;
  logic          hit_q;
  logic [IW-1:0] hid_q, eh_q, rt_q;
  logic [CW-1:0] ecnt_q, ecnt_d, rcnt_q, rcnt_d;
  bbcm_resp_t    resp_q, resp_d;
  logic          ovalid_q;

  // ring of cells
  bbcm_entry_t   ent  [NUM_BUFS];
  logic          em   [NUM_BUFS];
  logic          rm   [NUM_BUFS];
  logic [IW-1:0] epos [NUM_BUFS];
  logic [IW-1:0] rpos [NUM_BUFS];

  logic          shift;
  bbcm_bcast_t   bcast;
  logic [IW-1:0] tid;
  bbcm_entry_t   nx;
  logic          nem, nrm;
  logic [IW-1:0] nepos, nrpos, rdec_pos;

  for (genvar k = 0; k < NUM_BUFS; k++) begin : g_cell
    localparam int NB = (k + 1) % NUM_BUFS;
    bbcm_cell #(.IW(IW), .K(k)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .nbr_ent_i  (ent[NB]),
      .nbr_em_i   (em[NB]),
      .nbr_epos_i (epos[NB]),
      .nbr_rm_i   (rm[NB]),
      .nbr_rpos_i (rpos[NB]),
      .bcast_i    (bcast),
      .tgt_id_i   (tid),
      .tgt_ent_i  (nx),
      .tgt_em_i   (nem),
      .tgt_epos_i (nepos),
      .tgt_rm_i   (nrm),
      .tgt_rpos_i (nrpos),
      .rdec_pos_i (rdec_pos),
      .ent_o      (ent[k]),
      .em_o       (em[k]),
      .epos_o     (epos[k]),
      .rm_o       (rm[k]),
      .rpos_o     (rpos[k])
    );
  end

  // handshake
  logic in_fire, act_fire;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign act_fire    = (state_q == S_ACT) && (!ovalid_q || out_ready_i);
  assign shift       = (state_q == S_SCAN);
  assign out_valid_o = ovalid_q;
  assign out_resp_o  = resp_q;

  // compare stage at cell 0 during the rotation
  logic scan_hit, scan_eh, scan_rt;
  assign scan_hit = ent[0].in_cache && ent[0].dev == req_q.device_id
                    && ent[0].blk == req_q.block_number;
  assign scan_eh  = em[0] && epos[0] == '0;
  assign scan_rt  = rm[0] && {1'b0, rpos[0]} == (rcnt_q - CW'(1));

  // index of a non-acquire request, widened before narrowing to the pool index
  logic [8:0] bi_ext;
  logic       bi_oor;
  assign bi_ext = {4'b0, req_q.buffer_index};
  assign bi_oor = 32'(req_q.buffer_index) >= NUM_BUFS;

  bbcm_entry_t cur;
  logic        cem, crm;
  logic [IW-1:0] crpos;
  logic        drop_en, upd;
  logic [8:0]  tid_ext;

  always_comb begin
    bcast    = '0;
    upd      = 1'b0;
    drop_en  = 1'b0;
    rdec_pos = '0;
    ecnt_d   = ecnt_q;
    rcnt_d   = rcnt_q;
    resp_d   = '0;
    if (req_q.req_type == REQ_ACQUIRE) begin
      if (hit_q)           tid = hid_q;
      else if (ecnt_q != '0) tid = eh_q;
      else                 tid = rt_q;
    end else begin
      tid = bi_ext[IW-1:0];
    end
    cur   = ent[tid];
    cem   = em[tid];
    crm   = rm[tid];
    crpos = rpos[tid];
    nx    = cur;
    nem   = cem;
    nepos = epos[tid];
    nrm   = crm;
    nrpos = crpos;
    tid_ext = 9'(tid);
    resp_d.result_index = req_q.buffer_index;

    case (req_q.req_type)
      REQ_ACQUIRE: begin
        resp_d.result_index = tid_ext[4:0];
        if (hit_q) begin
          upd = 1'b1;
          if (cur.refs == '0 && crm) begin
            nrm         = 1'b0;
            bcast.r_dec = 1'b1;
            rdec_pos    = crpos;
            rcnt_d      = rcnt_d - CW'(1);
          end
          if (cur.refs != REF_MAX) nx.refs = cur.refs + 16'd1;
          if (cur.busy) begin
            resp_d.status = ST_PENDING;
          end else if (cur.err) begin
            drop_en       = 1'b1;
            resp_d.status = ST_IOERR;
          end else begin
            resp_d.status = ST_READY;
          end
        end else if (ecnt_q != '0 || rcnt_q != '0) begin
          upd = 1'b1;
          if (ecnt_q != '0) begin
            nem         = 1'b0;
            bcast.e_pop = 1'b1;
            ecnt_d      = ecnt_d - CW'(1);
          end else begin
            nrm    = 1'b0;
            rcnt_d = rcnt_d - CW'(1);
          end
          nx.dev      = req_q.device_id;
          nx.blk      = req_q.block_number;
          nx.refs     = 16'd1;
          nx.in_cache = 1'b1;
          nx.busy     = 1'b1;
          nx.err      = 1'b0;
          resp_d.status = ST_FILL;
        end else begin
          resp_d.result_index = '0;
          resp_d.status       = ST_NOBUF;
        end
      end
      REQ_POLL: begin
        if (bi_oor || cur.refs == '0) begin
          resp_d.status = ST_NOBUF;
        end else if (cur.busy) begin
          resp_d.status = ST_PENDING;
        end else if (cur.err) begin
          upd           = 1'b1;
          drop_en       = 1'b1;
          resp_d.status = ST_IOERR;
        end else begin
          resp_d.status = ST_READY;
        end
      end
      REQ_FILLED: begin
        if (bi_oor) begin
          resp_d.status = ST_NOBUF;
        end else begin
          if (cur.busy) begin
            upd     = 1'b1;
            nx.busy = 1'b0;
            nx.err  = req_q.read_error;
            drop_en = req_q.read_error;
          end
          resp_d.status = nx.err ? ST_IOERR : ST_READY;
        end
      end
      REQ_RELEASE: begin
        if (bi_oor || cur.refs == '0) begin
          resp_d.status = ST_NOBUF;
        end else begin
          upd           = 1'b1;
          drop_en       = 1'b1;
          resp_d.status = ST_RELEASED;
        end
      end
      default: begin
        resp_d.status = ST_NOBUF;
      end
    endcase

    // dropping a reference: at zero, error entries leave the cache for the
    // empty tail, others go to the recency head
    if (drop_en && nx.refs != '0) begin
      nx.refs = nx.refs - 16'd1;
      if (nx.refs == '0) begin
        if (nx.err) begin
          nx.in_cache = 1'b0;
          nem         = 1'b1;
          nepos       = ecnt_q[IW-1:0];
          ecnt_d      = ecnt_d + CW'(1);
        end else begin
          nrm         = 1'b1;
          nrpos       = '0;
          bcast.r_inc = 1'b1;
          rcnt_d      = rcnt_d + CW'(1);
        end
      end
    end

    bcast.tgt_we = upd;
    if (!act_fire) bcast = '0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = (in_req_i.req_type == REQ_ACQUIRE) ? S_SCAN : S_ACT;
      S_SCAN: if (cnt_q == IW'(NUM_BUFS - 1)) state_d = S_ACT;
      S_ACT:  if (act_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hit_q    <= 1'b0;
      ecnt_q   <= CW'(NUM_BUFS);
      rcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
      end else if (shift) begin
        cnt_q <= cnt_q + IW'(1);
        if (scan_hit && !hit_q) hit_q <= 1'b1;
      end
      if (act_fire) begin
        ecnt_q   <= ecnt_d;
        rcnt_q   <= rcnt_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_req_i;
    if (shift) begin
      if (scan_hit && !hit_q) hid_q <= cnt_q;
      if (scan_eh) eh_q <= cnt_q;
      if (scan_rt) rt_q <= cnt_q;
    end
    if (act_fire) resp_q <= resp_d;
  end

  // each entry sits on at most one list
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecnt_q) + 32'(rcnt_q) <= NUM_BUFS)
    else $error("list counts exceed pool size");

  a_act_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_fire |=> state_q == S_IDLE && out_valid_o)
    else $error("update cycle did not produce a response");

  a_acq_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.req_type == REQ_ACQUIRE |=> state_q == S_SCAN && cnt_q == '0)
    else $error("acquire did not start a tag scan");

  a_resp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_ACT)
    else $error("response raised outside update cycle");

endmodule
